// ===== hw/rtl/ftpf_pkg.sv =====
// Shared types, constants and codes of the five-tuple rule packet filter.
package ftpf_pkg;

    localparam int RULE_SLOTS = 16;
    localparam int IDX_W      = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W      = 5;

    localparam int RULE_W     = 2 + 32 + 32 + 16 + 16;

    localparam logic [15:0] ETH_IPV4      = 16'h0800;
    localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
    localparam logic [7:0]  IP_PROTO_TCP  = 8'd6;

    localparam logic [1:0]  CLASS_UDP     = 2'd1;
    localparam logic [1:0]  CLASS_TCP     = 2'd2;

    localparam logic [1:0]  MODE_WHITELIST = 2'd0;
    localparam logic [1:0]  MODE_BLACKLIST = 2'd1;

    localparam logic        ITEM_CLASSIFY = 1'b0;
    localparam logic        ITEM_WRITE    = 1'b1;

    localparam logic [1:0]  REG_FILTER_MODE = 2'd0;
    localparam logic [1:0]  REG_RULE_COUNT  = 2'd1;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic start;    // latch a classify item and read rule zero
        logic wr_rule;  // store the incoming rule
        logic advance;  // step to the next rule
        logic load;     // load the result register
    } t_cmd;

    typedef struct packed {
        logic done;     // current rule matched or it was the last one
        logic out_free; // result register can take a new result
    } t_stat;

endpackage

// ===== hw/rtl/five_tuple_rule_packet_filter.sv =====
// A classify item walks the rule table; its result is registered when the walk ends.
// A rule write item gives no result. At most RULE_SLOTS rules are compared.
// The walk over the registered-read rule RAM compares one rule a cycle; a finished walk waits while
// the result register is busy, and a new item is taken the cycle after its result is loaded.
// Reset (i_rst_n, synchronous, active low) clears the state machine, the result valid flag and both
// configuration registers; the rule table is not cleared and must be written before it is used.
module five_tuple_rule_packet_filter
    import ftpf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Input item channel.
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_mode,
    input  logic [3:0]       i_rule_index,
    input  logic [1:0]       i_rule_proto,
    input  logic [15:0]      i_ether_type,
    input  logic [7:0]       i_ip_proto,
    input  logic [31:0]      i_src_addr,
    input  logic [31:0]      i_dst_addr,
    input  logic [15:0]      i_sport,
    input  logic [15:0]      i_dport,
    // Result item channel.
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_forward,
    output logic             o_matched,
    output logic [3:0]       o_match_index,
    // Configuration write port.
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [CNT_W-1:0] i_cfg_data
);

    // The controller issues at most one command per cycle to the datapath and watches
    // two status bits: whether the walk is finished and whether the result
    // register can take a new result.
    t_cmd  cmd;
    t_stat stat;

    // The controller takes an item only while idle. A rule write is stored in
    // the same cycle; a classify item latches its header and starts the walk.
    ftpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // The datapath holds the rule RAM, compares one rule per cycle against the
    // latched header, and keeps the result in an output register so that the
    // next item can be taken while a finished result still waits downstream.
    // Frames that are not IPv4 finish on the first compare with no match.
    ftpf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_rule_index  (i_rule_index),
        .i_rule_proto  (i_rule_proto),
        .i_ether_type  (i_ether_type),
        .i_ip_proto    (i_ip_proto),
        .i_src_addr    (i_src_addr),
        .i_dst_addr    (i_dst_addr),
        .i_sport       (i_sport),
        .i_dport       (i_dport),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_forward     (o_forward),
        .o_matched     (o_matched),
        .o_match_index (o_match_index)
    );

endmodule

// ===== hw/rtl/ftpf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ftpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ftpf_ctrl.sv =====
// Controller state machine that sequences rule writes and the rule walk.
module ftpf_ctrl
    import ftpf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_mode,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_mode == ITEM_WRITE) begin
                        o_cmd.wr_rule = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.done) begin
                    if (i_stat.out_free) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.start, o_cmd.wr_rule, o_cmd.advance, o_cmd.load}))
        else $error("more than one datapath command at once");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (i_stat.out_free && r_state == S_SCAN))
        else $error("result loaded while the result register is busy");

    a_start_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == S_SCAN && o_in_stall))
        else $error("classify item did not start a rule walk");
`endif

endmodule

// ===== hw/rtl/ftpf_dp.sv =====
// Datapath: configuration registers, rule table, rule compare and result register.
module ftpf_dp
    import ftpf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  logic [3:0]       i_rule_index,
    input  logic [1:0]       i_rule_proto,
    input  logic [15:0]      i_ether_type,
    input  logic [7:0]       i_ip_proto,
    input  logic [31:0]      i_src_addr,
    input  logic [31:0]      i_dst_addr,
    input  logic [15:0]      i_sport,
    input  logic [15:0]      i_dport,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic             o_forward,
    output logic             o_matched,
    output logic [3:0]       o_match_index
);

    logic [1:0]       r_filter_mode;
    logic [CNT_W-1:0] r_rule_count;

    logic             r_ipv4;
    logic [7:0]       r_ip_proto;
    logic [31:0]      r_src_addr;
    logic [31:0]      r_dst_addr;
    logic [15:0]      r_sport;
    logic [15:0]      r_dport;
    logic [CNT_W-1:0] r_limit;
    logic [IDX_W-1:0] r_idx;

    logic             r_out_valid;
    logic             r_forward;
    logic             r_matched;
    logic [3:0]       r_match_index;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [RULE_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [RULE_W-1:0] ram_rdata;

    logic [1:0]       rule_cls;
    logic [31:0]      rule_sa;
    logic [31:0]      rule_da;
    logic [15:0]      rule_sp;
    logic [15:0]      rule_dp;
    logic             proto_ok;
    logic             rule_hit;
    logic             last_rule;
    logic [CNT_W-1:0] limit_in;
    logic             fwd;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode <= MODE_WHITELIST;
            r_rule_count  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FILTER_MODE: r_filter_mode <= i_cfg_data[1:0];
                REG_RULE_COUNT:  r_rule_count  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Rule table.
    assign ram_we    = i_cmd.wr_rule && (32'(i_rule_index) < 32'(RULE_SLOTS));
    assign ram_waddr = IDX_W'(i_rule_index);
    assign ram_wdata = {i_rule_proto, i_src_addr, i_dst_addr, i_sport, i_dport};

    always_comb begin
        if (i_cmd.start) begin
            ram_raddr = '0;
        end else if (i_cmd.advance) begin
            ram_raddr = r_idx + IDX_W'(1);
        end else begin
            ram_raddr = r_idx;
        end
    end

    ftpf_ram #(
        .WIDTH (RULE_W),
        .DEPTH (RULE_SLOTS)
    ) u_rules (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Packet header and walk position.
    assign limit_in = (32'(r_rule_count) > 32'(RULE_SLOTS)) ? CNT_W'(RULE_SLOTS)
                                                             : r_rule_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ipv4     <= (i_ether_type == ETH_IPV4);
            r_ip_proto <= i_ip_proto;
            r_src_addr <= i_src_addr;
            r_dst_addr <= i_dst_addr;
            r_sport    <= i_sport;
            r_dport    <= i_dport;
            r_limit    <= limit_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.start) begin
            r_idx <= '0;
        end else if (i_cmd.advance) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // Compare the rule on the RAM output with the latched header.
    assign {rule_cls, rule_sa, rule_da, rule_sp, rule_dp} = ram_rdata;

    always_comb begin
        case (rule_cls)
            CLASS_UDP: proto_ok = (r_ip_proto == IP_PROTO_UDP);
            CLASS_TCP: proto_ok = (r_ip_proto == IP_PROTO_TCP);
            default:   proto_ok = 1'b1;
        endcase
    end

    assign rule_hit = r_ipv4 && (r_limit != '0) && proto_ok
                   && (rule_sa == '0 || rule_sa == r_src_addr)
                   && (rule_da == '0 || rule_da == r_dst_addr)
                   && (rule_sp == '0 || rule_sp == r_sport)
                   && (rule_dp == '0 || rule_dp == r_dport);

    assign last_rule = !r_ipv4 || ((CNT_W'(r_idx) + CNT_W'(1)) >= r_limit);

    assign o_stat.done     = rule_hit || last_rule;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        if (!r_ipv4) begin
            fwd = 1'b1;
        end else begin
            case (r_filter_mode)
                MODE_WHITELIST: fwd = rule_hit;
                MODE_BLACKLIST: fwd = !rule_hit;
                default:        fwd = 1'b0;
            endcase
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_forward     <= fwd;
            r_matched     <= rule_hit;
            r_match_index <= rule_hit ? 4'(r_idx) : 4'd0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_forward     = r_forward;
    assign o_matched     = r_matched;
    assign o_match_index = r_match_index;

`ifndef SYNTHESIS
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.advance |-> ((CNT_W'(r_idx) + CNT_W'(1)) < r_limit))
        else $error("rule walk stepped past the rule count");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_matched) |-> (r_match_index == 4'd0))
        else $error("match index not zero on a frame without a match");

    a_advance_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.advance |=> (r_idx == $past(r_idx) + IDX_W'(1)))
        else $error("walk position did not follow the advance command");
`endif

endmodule
